@@ rtl/fdiv_pkg.sv @@
// Package for the float32 divider: status codes, word carried down the cell chain.
// No dependencies.
`timescale 1ns / 1ps
package fdiv_pkg;

   localparam int unsigned FRAC_W  = 23;
   localparam int unsigned MANT_W  = 24;
   localparam int unsigned EXP_W   = 8;
   localparam int unsigned Q_W     = 47;   // floor(ma*2^23/mb) fits in 47 bits
   localparam int unsigned SHIFT_W = 7;
   localparam logic [31:0] POS_INF = 32'h7F80_0000;
   localparam logic [9:0]  BIAS    = 10'd127;
   localparam logic [9:0]  EXP_MAX = 10'd255;

   typedef enum logic [2:0] {
      ST_NORMAL        = 3'd0,
      ST_ZERO_DIVIDEND = 3'd1,
      ST_DIV_BY_ZERO   = 3'd2,
      ST_OVERFLOW      = 3'd3,
      ST_UNDERFLOW     = 3'd4
   } status_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic                sign;
      logic [EXP_W-1:0]    exp;
      logic [MANT_W-1:0]   ma;
      logic [MANT_W-1:0]   mb;
      logic [MANT_W-1:0]   rem;
      logic [Q_W-1:0]      q;
   } word_type;

endpackage

@@ rtl/fdiv_cell.sv @@
// One restoring-division cell: settles one quotient bit and passes the word on.
// Depends on fdiv_pkg.
`timescale 1ns / 1ps
module fdiv_cell #(
   parameter int unsigned QBIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  fdiv_pkg::word_type up_word,
   output fdiv_pkg::word_type dn_word
);
   import fdiv_pkg::*;

   word_type           word_ff, word_in;
   logic               dbit;
   logic [MANT_W:0]    trial;
   logic               fits;

   // dividend is ma shifted up by 23; bits below 23 are zero
   generate
      if (QBIT >= FRAC_W) begin : g_hi
         assign dbit = up_word.ma[QBIT-FRAC_W];
      end else begin : g_lo
         assign dbit = 1'b0;
      end
   endgenerate

   always_comb begin
      trial   = {up_word.rem, dbit};
      fits    = trial >= {1'b0, up_word.mb};
      word_in = up_word;
      if (fits) begin
         word_in.rem = MANT_W'(trial - {1'b0, up_word.mb});
      end else begin
         word_in.rem = trial[MANT_W-1:0];
      end
      word_in.q = {up_word.q[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in.valid;
      end
      word_ff.status <= word_in.status;
      word_ff.sign   <= word_in.sign;
      word_ff.exp    <= word_in.exp;
      word_ff.ma     <= word_in.ma;
      word_ff.mb     <= word_in.mb;
      word_ff.rem    <= word_in.rem;
      word_ff.q      <= word_in.q;
   end

   assign dn_word = word_ff;

endmodule

@@ rtl/fdiv_norm.sv @@
// Normalise and pack: shift count search, then shift, exponent fix and result select.
// Depends on fdiv_pkg.
`timescale 1ns / 1ps
module fdiv_norm (
   input  logic               clock,
   input  logic               reset,
   input  fdiv_pkg::word_type up_word,
   output logic               out_valid,
   output logic [31:0]        out_bits,
   output logic [2:0]         out_status
);
   import fdiv_pkg::*;

   // stage 1: shift search
   logic               v1_ff;
   status_type         st1_ff;
   logic               sign1_ff;
   logic [EXP_W-1:0]   exp1_ff;
   logic [Q_W-1:0]     q1_ff;
   logic               lowz1_ff, lowz1_in;
   logic [SHIFT_W-1:0] s1_ff, s1_in;

   always_comb begin
      lowz1_in = (up_word.q[MANT_W-1:0] == '0);
      s1_in    = '0;
      if (!lowz1_in) begin
         for (int i = 0; i < MANT_W; i++) begin
            if (up_word.q[i]) s1_in = SHIFT_W'(FRAC_W - i);
         end
      end else begin
         // only high bits set: they all shift out past bit 63
         for (int i = Q_W - 1; i >= MANT_W; i--) begin
            if (up_word.q[i]) s1_in = SHIFT_W'(64 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= up_word.valid;
      end
      st1_ff   <= up_word.status;
      sign1_ff <= up_word.sign;
      exp1_ff  <= up_word.exp;
      q1_ff    <= up_word.q;
      lowz1_ff <= lowz1_in;
      s1_ff    <= s1_in;
   end

   // stage 2: shift and pack
   logic              v2_ff;
   logic [31:0]       bits2_ff, bits2_in;
   logic [2:0]        st2_ff;
   logic [MANT_W:0]   sh;
   logic [EXP_W-1:0]  e_base;
   logic [EXP_W-1:0]  e_fin;
   logic [FRAC_W-1:0] frac;

   always_comb begin
      sh     = (MANT_W+1)'({1'b0, q1_ff} << s1_ff[4:0]);
      e_base = exp1_ff - EXP_W'({1'b0, s1_ff});
      if (lowz1_ff) begin
         frac  = '0;
         e_fin = e_base;
      end else if (sh[MANT_W]) begin
         frac  = sh[MANT_W-1:1];
         e_fin = e_base + EXP_W'(1);
      end else begin
         frac  = sh[FRAC_W-1:0];
         e_fin = e_base;
      end
      unique case (st1_ff)
         ST_NORMAL:                     bits2_in = {sign1_ff, e_fin, frac};
         ST_DIV_BY_ZERO, ST_OVERFLOW:   bits2_in = POS_INF;
         ST_ZERO_DIVIDEND, ST_UNDERFLOW: bits2_in = '0;
         default:                       bits2_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      bits2_ff <= bits2_in;
      st2_ff   <= st1_ff;
   end

   assign out_valid  = v2_ff;
   assign out_bits   = bits2_ff;
   assign out_status = st2_ff;

endmodule

@@ rtl/float32_divider_unit.sv @@
// Stages a word passes, each registered: 1 decode, 47 cells, 2 pack.
// Throughput: one word per cycle while busy is low; a 47-cell restoring chain settles one quotient bit per cell.
// Reset: synchronous, clears all valid flags; busy follows reset so nothing is taken then.
// The receiver cannot stall: rsp_valid is high for a single cycle per result word.
// Top level of the float32 divider; depends on fdiv_pkg, fdiv_cell, fdiv_norm.
`timescale 1ns / 1ps
module float32_divider_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_dividend_bits,
   input  logic [31:0] req_divisor_bits,
   output logic        rsp_valid,
   output logic [31:0] rsp_quotient_bits,
   output logic [2:0]  rsp_status
);
   import fdiv_pkg::*;

   word_type          word_ff, word_in;
   word_type          chain [0:Q_W];
   logic [EXP_W-1:0]  ea, eb;
   logic signed [9:0] exp_wide;

   assign busy = reset;

   always_comb begin
      ea       = req_dividend_bits[30:23];
      eb       = req_divisor_bits[30:23];
      exp_wide = $signed({2'b00, ea}) - $signed({2'b00, eb}) + $signed(BIAS);
      word_in.valid = start && !busy;
      word_in.sign  = req_dividend_bits[31] ^ req_divisor_bits[31];
      word_in.exp   = exp_wide[EXP_W-1:0];
      word_in.ma    = {ea != '0, req_dividend_bits[FRAC_W-1:0]};
      word_in.mb    = {eb != '0, req_divisor_bits[FRAC_W-1:0]};
      word_in.rem   = '0;
      word_in.q     = '0;
      priority if (req_dividend_bits[30:0] == '0) begin
         word_in.status = ST_ZERO_DIVIDEND;
      end else if (req_divisor_bits[30:0] == '0) begin
         word_in.status = ST_DIV_BY_ZERO;
      end else if (exp_wide >= $signed(EXP_MAX)) begin
         word_in.status = ST_OVERFLOW;
      end else if (exp_wide <= 10'sd0) begin
         word_in.status = ST_UNDERFLOW;
      end else begin
         word_in.status = ST_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff.valid <= word_in.valid;
      end
      word_ff.status <= word_in.status;
      word_ff.sign   <= word_in.sign;
      word_ff.exp    <= word_in.exp;
      word_ff.ma     <= word_in.ma;
      word_ff.mb     <= word_in.mb;
      word_ff.rem    <= word_in.rem;
      word_ff.q      <= word_in.q;
   end

   assign chain[0] = word_ff;

   // cell k settles quotient bit Q_W-1-k, MSB first
   generate
      for (genvar k = 0; k < Q_W; k++) begin : g_cell
         fdiv_cell #(.QBIT(Q_W - 1 - k)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .up_word (chain[k]),
            .dn_word (chain[k+1])
         );
      end
   endgenerate

   fdiv_norm u_norm (
      .clock      (clock),
      .reset      (reset),
      .up_word    (chain[Q_W]),
      .out_valid  (rsp_valid),
      .out_bits   (rsp_quotient_bits),
      .out_status (rsp_status)
   );

endmodule

@@ rtl/fdiv_checker.sv @@
// Port-level checks on the float32 divider, bound to the top level.
// Depends on fdiv_pkg and float32_divider_unit.
`timescale 1ns / 1ps
module fdiv_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_quotient_bits,
   input logic [2:0]  rsp_status
);
   import fdiv_pkg::*;

   a_busy_in_reset: assert property (@(posedge clock) reset |-> busy)
      else $error("busy low during reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_UNDERFLOW))
      else $error("status code out of range");

   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ZERO_DIVIDEND || rsp_status == ST_UNDERFLOW)
      |-> rsp_quotient_bits == '0)
      else $error("zero result word expected");

   a_inf_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DIV_BY_ZERO || rsp_status == ST_OVERFLOW)
      |-> rsp_quotient_bits == POS_INF)
      else $error("infinity result word expected");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(start && !busy, 50))
      else $error("result strobe without a taken word");

endmodule

bind float32_divider_unit fdiv_checker u_fdiv_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_quotient_bits (rsp_quotient_bits),
   .rsp_status        (rsp_status)
);
